@@ hw/rtl/ftt_pkg.sv @@
// ftt_pkg: shared types and constants of the flow tracking table
// payload structs, status codes, register indexes and reset values
// no dependencies
`default_nettype none

package ftt_pkg;

  typedef enum logic [3:0] {
    STAT_IGNORED   = 4'd0,
    STAT_CTRL_NEW  = 4'd1,
    STAT_CTRL_SEEN = 4'd2,
    STAT_CTRL_CLOS = 4'd3,
    STAT_DATA_NEW  = 4'd4,
    STAT_DATA_SEEN = 4'd5,
    STAT_DATA_CLOS = 4'd6,
    STAT_NO_ROOM   = 4'd7,
    STAT_CTRL_UNTR = 4'd8
  } status_e;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CONTROL_PORT   = 3'd0,
    REG_DATA_PORT_LOW  = 3'd1,
    REG_DATA_PORT_HIGH = 3'd2,
    REG_IDLE_TIMEOUT   = 3'd3,
    REG_FTP_COLOR      = 3'd4
  } reg_idx_e;

  localparam logic [15:0] RstControlPort  = 16'd2811;
  localparam logic [15:0] RstDataPortLow  = 16'd20000;
  localparam logic [15:0] RstDataPortHigh = 16'd25000;
  localparam logic [31:0] RstIdleTimeout  = 32'd60;
  localparam logic [7:0]  RstFtpColor     = 8'd1;

  localparam logic [1:0] CloseCount = 2'd2;
  localparam logic [1:0] SatCount   = 2'd3;

  typedef struct packed {
    logic [7:0]  packet_color;
    logic        is_tcp_ipv4;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        flag_syn;
    logic        flag_fin;
    logic        flag_ack;
    logic [31:0] now_seconds;
  } pkt_t;

  typedef struct packed {
    logic    accept;
    logic    mark_color;
    status_e status;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] addr;
    logic [31:0]        wdata;
  } cfg_t;

  typedef struct packed {
    logic [63:0] hosts;
    logic [31:0] ports;
  } key_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  fin_cnt;
    logic [1:0]  ack_cnt;
    logic [31:0] ts;
  } cmeta_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ts;
  } dmeta_t;

  typedef struct packed {
    key_t   key;
    cmeta_t meta;
  } cent_t;

  typedef struct packed {
    key_t   key;
    dmeta_t meta;
  } dent_t;

endpackage

`default_nettype wire

@@ hw/rtl/ftt_if.sv @@
// ftt_if: valid/ready channels for packets, results and register writes
// depends on ftt_pkg
`default_nettype none

interface ftt_pkt_if;
  import ftt_pkg::*;
  logic valid;
  logic ready;
  pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ftt_res_if;
  import ftt_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ftt_cfg_if;
  import ftt_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ftp_flow_tracking_table_core.sv @@
// ftp_flow_tracking_table_core: control and data flow tables for one packet a time
// depends on ftt_pkg, ftt_if and ftt_bucket_hash
//
// channel | dir | handshake       | payload
// pkt_i   | in  | valid/ready     | header fields and time
// res_o   | out | valid/ready     | accept, mark_color, status
// cfg_i   | in  | valid/ready (1) | register index and write data
//
// a request passes the bucket remainder, its hand-over, the memory read, then evaluation
// and write back, after which a new request is accepted; the result is registered at write back
// a waiting result holds the write back, and with it the next request
// after reset a clearing pass over all HASH_BUCKETS buckets zeroes both meta rows,
// packets are refused meanwhile; register writes are always taken
`default_nettype none

module ftp_flow_tracking_table_core #(
  parameter int unsigned HASH_BUCKETS = 256,
  parameter int unsigned BUCKET_WAYS  = 4
) (
  input logic clk_i,
  input logic rst_ni,
  ftt_pkt_if.sink   pkt_i,
  ftt_cfg_if.sink   cfg_i,
  ftt_res_if.source res_o
);
  import ftt_pkg::*;

  localparam int unsigned BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
  localparam int unsigned WW = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_EVAL  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [BW-1:0] clr_q;
  pkt_t        pkt_q;
  res_t        res_q, res_d;
  logic        res_valid_q;

  logic [15:0] ctrl_port_q, dlow_q, dhigh_q;
  logic [31:0] idle_to_q;
  logic [7:0]  color_q;

  logic          hash_done;
  logic [BW-1:0] bucket;

  cent_t ctrl_mem [HASH_BUCKETS][BUCKET_WAYS];
  dent_t data_mem [HASH_BUCKETS][BUCKET_WAYS];
  cent_t ctrl_rd_q [BUCKET_WAYS];
  dent_t data_rd_q [BUCKET_WAYS];

  cmeta_t        c_new [BUCKET_WAYS];
  dmeta_t        d_new [BUCKET_WAYS];
  logic          ckey_we, dkey_we;
  logic [WW-1:0] kway;
  logic          eval_go, mem_we;
  logic [BW-1:0] mem_addr;

  wire pkt_acc = pkt_i.valid && pkt_i.ready;

  assign pkt_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  ftt_bucket_hash #(.HASH_BUCKETS(HASH_BUCKETS)) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (pkt_acc),
    .sum_i    (pkt_i.data.src_addr + pkt_i.data.dst_addr),
    .bucket_o (bucket),
    .done_o   (hash_done)
  );

  assign eval_go  = (state_q == S_EVAL) && (!res_valid_q || res_o.ready);
  assign mem_we   = (state_q == S_CLEAR) || eval_go;
  assign mem_addr = (state_q == S_CLEAR) ? clr_q : bucket;

  always_comb begin
    logic [63:0] hf, hr;
    logic [31:0] pf, pr;
    logic        color_ok, is_ctrl, in_range, joined;
    logic        c_hit, d_hit, found;
    logic [WW-1:0] c_hidx, d_hidx, fidx;
    logic [BUCKET_WAYS-1:0] c_match, d_match, c_host, d_host, c_idle, d_idle;
    logic [1:0]  fc, ac;
    hf = {pkt_q.src_addr, pkt_q.dst_addr};
    hr = {pkt_q.dst_addr, pkt_q.src_addr};
    pf = {pkt_q.src_port, pkt_q.dst_port};
    pr = {pkt_q.dst_port, pkt_q.src_port};
    color_ok = (pkt_q.packet_color == 8'd0) || (pkt_q.packet_color == color_q);
    is_ctrl  = (pkt_q.src_port == ctrl_port_q) || (pkt_q.dst_port == ctrl_port_q);
    in_range = ((pkt_q.src_port >= dlow_q) && (pkt_q.src_port <= dhigh_q)) ||
               ((pkt_q.dst_port >= dlow_q) && (pkt_q.dst_port <= dhigh_q));
    c_hit = 1'b0; d_hit = 1'b0; c_hidx = '0; d_hidx = '0;
    found = 1'b0; fidx = '0; joined = 1'b0;
    fc = '0; ac = '0;
    for (int w = 0; w < BUCKET_WAYS; w++) begin
      c_new[w] = ctrl_rd_q[w].meta;
      d_new[w] = data_rd_q[w].meta;
      c_host[w] = ctrl_rd_q[w].meta.valid &&
                  (ctrl_rd_q[w].key.hosts == hf || ctrl_rd_q[w].key.hosts == hr);
      d_host[w] = data_rd_q[w].meta.valid &&
                  (data_rd_q[w].key.hosts == hf || data_rd_q[w].key.hosts == hr);
      c_match[w] = ctrl_rd_q[w].meta.valid &&
                   ((ctrl_rd_q[w].key.hosts == hf && ctrl_rd_q[w].key.ports == pf) ||
                    (ctrl_rd_q[w].key.hosts == hr && ctrl_rd_q[w].key.ports == pr));
      d_match[w] = data_rd_q[w].meta.valid &&
                   ((data_rd_q[w].key.hosts == hf && data_rd_q[w].key.ports == pf) ||
                    (data_rd_q[w].key.hosts == hr && data_rd_q[w].key.ports == pr));
      c_idle[w] = (pkt_q.now_seconds - ctrl_rd_q[w].meta.ts) > idle_to_q;
      d_idle[w] = (pkt_q.now_seconds - data_rd_q[w].meta.ts) > idle_to_q;
      if (!c_hit && c_match[w]) begin
        c_hit = 1'b1;
        c_hidx = WW'(w);
      end
      if (!d_hit && d_match[w]) begin
        d_hit = 1'b1;
        d_hidx = WW'(w);
      end
      if (c_host[w]) joined = 1'b1;
    end
    ckey_we = 1'b0;
    dkey_we = 1'b0;
    kway    = '0;
    res_d   = '{accept: 1'b0, mark_color: 1'b0, status: STAT_IGNORED};
    if (color_ok && pkt_q.is_tcp_ipv4) begin
      if (is_ctrl) begin
        for (int w = 0; w < BUCKET_WAYS; w++) begin
          if (ctrl_rd_q[w].meta.valid && !(c_hit && c_hidx == WW'(w)) && c_idle[w])
            c_new[w] = '0;
        end
        if (c_hit) begin
          fc = ctrl_rd_q[c_hidx].meta.fin_cnt;
          ac = ctrl_rd_q[c_hidx].meta.ack_cnt;
          if (pkt_q.flag_fin && fc != SatCount) fc = fc + 2'd1;
          if (fc == CloseCount && pkt_q.flag_ack && ac != SatCount) ac = ac + 2'd1;
          if (fc == CloseCount && ac == CloseCount) begin
            c_new[c_hidx] = '0;
            for (int w = 0; w < BUCKET_WAYS; w++) begin
              if (d_host[w]) d_new[w] = '0;
            end
            res_d = '{accept: 1'b1, mark_color: 1'b1, status: STAT_CTRL_CLOS};
          end else begin
            c_new[c_hidx] = '{valid: 1'b1, fin_cnt: fc, ack_cnt: ac, ts: pkt_q.now_seconds};
            res_d = '{accept: 1'b1, mark_color: 1'b1, status: STAT_CTRL_SEEN};
          end
        end else if (!pkt_q.flag_syn) begin
          res_d = '{accept: 1'b1, mark_color: 1'b0, status: STAT_CTRL_UNTR};
        end else begin
          for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (!found && !c_new[w].valid) begin
              found = 1'b1;
              fidx = WW'(w);
            end
          end
          if (!found) begin
            res_d = '{accept: 1'b1, mark_color: 1'b1, status: STAT_NO_ROOM};
          end else begin
            c_new[fidx] = '{valid: 1'b1, fin_cnt: 2'd0, ack_cnt: 2'd0,
                            ts: pkt_q.now_seconds};
            ckey_we = 1'b1;
            kway    = fidx;
            res_d = '{accept: 1'b1, mark_color: 1'b1, status: STAT_CTRL_NEW};
          end
        end
      end else begin
        for (int w = 0; w < BUCKET_WAYS; w++) begin
          if (data_rd_q[w].meta.valid && !(d_hit && d_hidx == WW'(w)) && d_idle[w])
            d_new[w] = '0;
        end
        if (d_hit) begin
          if (pkt_q.flag_fin && pkt_q.flag_ack) begin
            d_new[d_hidx] = '0;
            res_d = '{accept: 1'b1, mark_color: 1'b1, status: STAT_DATA_CLOS};
          end else begin
            d_new[d_hidx] = '{valid: 1'b1, ts: pkt_q.now_seconds};
            res_d = '{accept: 1'b1, mark_color: 1'b1, status: STAT_DATA_SEEN};
          end
        end else if (in_range && joined) begin
          for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (!found && !d_new[w].valid) begin
              found = 1'b1;
              fidx = WW'(w);
            end
          end
          if (!found) begin
            res_d = '{accept: 1'b1, mark_color: 1'b1, status: STAT_NO_ROOM};
          end else begin
            d_new[fidx] = '{valid: 1'b1, ts: pkt_q.now_seconds};
            dkey_we = 1'b1;
            kway    = fidx;
            res_d = '{accept: 1'b1, mark_color: 1'b1, status: STAT_DATA_NEW};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      ctrl_rd_q <= ctrl_mem[bucket];
      data_rd_q <= data_mem[bucket];
    end
    if (mem_we) begin
      for (int w = 0; w < BUCKET_WAYS; w++) begin
        ctrl_mem[mem_addr][w].meta <= (state_q == S_CLEAR) ? '0 : c_new[w];
        data_mem[mem_addr][w].meta <= (state_q == S_CLEAR) ? '0 : d_new[w];
        if (eval_go && ckey_we && kway == WW'(w))
          ctrl_mem[mem_addr][w].key <= '{hosts: {pkt_q.src_addr, pkt_q.dst_addr},
                                         ports: {pkt_q.src_port, pkt_q.dst_port}};
        if (eval_go && dkey_we && kway == WW'(w))
          data_mem[mem_addr][w].key <= '{hosts: {pkt_q.src_addr, pkt_q.dst_addr},
                                         ports: {pkt_q.src_port, pkt_q.dst_port}};
      end
    end
    if (pkt_acc) pkt_q <= pkt_i.data;
    if (eval_go) res_q <= res_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == BW'(HASH_BUCKETS - 1)) state_d = S_IDLE;
      S_IDLE:  if (pkt_acc) state_d = S_HASH;
      S_HASH:  if (hash_done) state_d = S_READ;
      S_READ:  state_d = S_EVAL;
      S_EVAL:  if (eval_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      ctrl_port_q <= RstControlPort;
      dlow_q      <= RstDataPortLow;
      dhigh_q     <= RstDataPortHigh;
      idle_to_q   <= RstIdleTimeout;
      color_q     <= RstFtpColor;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + BW'(1);
      if (eval_go) res_valid_q <= 1'b1;
      else if (res_o.ready) res_valid_q <= 1'b0;
      if (cfg_i.valid) begin
        case (cfg_i.data.addr)
          REG_CONTROL_PORT:   ctrl_port_q <= cfg_i.data.wdata[15:0];
          REG_DATA_PORT_LOW:  dlow_q      <= cfg_i.data.wdata[15:0];
          REG_DATA_PORT_HIGH: dhigh_q     <= cfg_i.data.wdata[15:0];
          REG_IDLE_TIMEOUT:   idle_to_q   <= cfg_i.data.wdata;
          REG_FTP_COLOR:      color_q     <= cfg_i.data.wdata[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ftt_bucket_hash.sv @@
// ftt_bucket_hash: bucket index as a 32-bit sum modulo the bucket count
// reciprocal multiply, quotient and remainder, each registered in turn, a mask for a power of two
// no dependencies
`default_nettype none

module ftt_bucket_hash #(
  parameter int unsigned HASH_BUCKETS = 256,
  localparam int unsigned BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   sum_i,
  output logic [BW-1:0] bucket_o,
  output logic          done_o
);

  localparam int unsigned Lg     = $clog2(HASH_BUCKETS);
  localparam bit          IsPow2 = (HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0;
  localparam int unsigned QShift = (Lg > 0) ? Lg - 1 : 0;
  localparam logic [31:0] Mask   = 32'(HASH_BUCKETS - 1);
  localparam logic [16:0] DivC   = 17'(HASH_BUCKETS);
  localparam logic [63:0] MagicW =
    (((64'd1 << Lg) - 64'(HASH_BUCKETS)) << 32) / 64'(HASH_BUCKETS) + 64'd1;
  localparam logic [31:0] Magic  = MagicW[31:0];

  logic [31:0]   x_q, t_q, q_q;
  logic [BW-1:0] rem_q;
  logic [3:0]    stg_q;
  logic [63:0]   mprod;
  logic [48:0]   qprod;
  logic [31:0]   qsum, diff;

  // quotient by multiply-high with a rounding fixup, then remainder
  always_comb begin
    mprod = {32'd0, x_q} * {32'd0, Magic};
    qsum  = t_q + ((x_q - t_q) >> 1);
    qprod = {17'd0, q_q} * {32'd0, DivC};
    diff  = IsPow2 ? (x_q & Mask) : (x_q - qprod[31:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      t_q   <= '0;
      q_q   <= '0;
      rem_q <= '0;
      stg_q <= '0;
    end else begin
      stg_q <= {stg_q[2:0], start_i};
      if (start_i) x_q <= sum_i;
      t_q   <= mprod[63:32];
      q_q   <= qsum >> QShift;
      rem_q <= diff[BW-1:0];
    end
  end

  assign bucket_o = rem_q;
  assign done_o   = stg_q[3];

endmodule

`default_nettype wire

@@ test/ftp_flow_tracking_table_core_tb.sv @@
// ftp_flow_tracking_table_core_tb: self-checking bench for the flow tracking table core
// drives packet and register channels, with random idling on packets and result ready,
// predicts every result in a behavioral table model; depends on ftt_pkg, ftt_if and the core
`default_nettype none

module ftp_flow_tracking_table_core_tb;
  import ftt_pkg::*;

  localparam int unsigned NBUCKET = 256;
  localparam int unsigned NWAY = 4;
  localparam int unsigned NENT = NBUCKET * NWAY;
  localparam int unsigned STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ftt_pkt_if pkt_if ();
  ftt_cfg_if cfg_if ();
  ftt_res_if res_if ();

  ftp_flow_tracking_table_core #(
    .HASH_BUCKETS(NBUCKET),
    .BUCKET_WAYS (NWAY)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pkt_i (pkt_if.sink),
    .cfg_i (cfg_if.sink),
    .res_o (res_if.source)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [15:0] ctl_port, dlo, dhi;
  logic [31:0] idle_tmo;
  logic [7:0]  own_color;
  cent_t ctl_tab [NENT];
  dent_t dat_tab [NENT];

  res_t expected_q[$];
  int   mismatches = 0;
  bit   quiet_mode = 1'b0;
  int   idle_cnt = 0;
  logic [31:0] clock_s = 32'd1000;

  function automatic res_t mk(logic a, logic m, status_e s);
    res_t r;
    r.accept = a;
    r.mark_color = m;
    r.status = s;
    return r;
  endfunction

  function automatic bit is_stale(logic [31:0] last, logic [31:0] now);
    logic [31:0] d;
    d = now - last;
    return d > idle_tmo;
  endfunction

  function automatic res_t classify_packet(pkt_t p);
    logic [63:0] hf, hr;
    logic [31:0] pf, pr, sum;
    int base, hit, fw, e;
    logic [1:0] fc, ac;
    bit joined;
    hf = {p.src_addr, p.dst_addr};
    hr = {p.dst_addr, p.src_addr};
    pf = {p.src_port, p.dst_port};
    pr = {p.dst_port, p.src_port};
    sum = p.src_addr + p.dst_addr;
    base = int'(sum % NBUCKET) * NWAY;
    hit = -1;
    fw = -1;
    joined = 1'b0;
    if (p.packet_color != 0 && p.packet_color != own_color) return mk(0, 0, STAT_IGNORED);
    if (!p.is_tcp_ipv4) return mk(0, 0, STAT_IGNORED);
    if (p.src_port == ctl_port || p.dst_port == ctl_port) begin
      for (int w = 0; w < NWAY; w++) begin
        e = base + w;
        if (!ctl_tab[e].meta.valid) continue;
        if (hit < 0 && ((ctl_tab[e].key.hosts == hf && ctl_tab[e].key.ports == pf) ||
                        (ctl_tab[e].key.hosts == hr && ctl_tab[e].key.ports == pr)))
          hit = w;
        else if (is_stale(ctl_tab[e].meta.ts, p.now_seconds))
          ctl_tab[e].meta = '0;
      end
      if (hit >= 0) begin
        e = base + hit;
        fc = ctl_tab[e].meta.fin_cnt;
        ac = ctl_tab[e].meta.ack_cnt;
        if (p.flag_fin && fc < SatCount) fc++;
        if (fc == CloseCount && p.flag_ack && ac < SatCount) ac++;
        if (fc == CloseCount && ac == CloseCount) begin
          ctl_tab[e].meta = '0;
          for (int w = 0; w < NWAY; w++)
            if (dat_tab[base + w].meta.valid && (dat_tab[base + w].key.hosts == hf ||
                                                 dat_tab[base + w].key.hosts == hr))
              dat_tab[base + w].meta = '0;
          return mk(1, 1, STAT_CTRL_CLOS);
        end
        ctl_tab[e].meta = {1'b1, fc, ac, p.now_seconds};
        return mk(1, 1, STAT_CTRL_SEEN);
      end
      if (!p.flag_syn) return mk(1, 0, STAT_CTRL_UNTR);
      for (int w = 0; w < NWAY; w++)
        if (fw < 0 && !ctl_tab[base + w].meta.valid) fw = w;
      if (fw < 0) return mk(1, 1, STAT_NO_ROOM);
      ctl_tab[base + fw].key = {hf, pf};
      ctl_tab[base + fw].meta = {1'b1, 2'b0, 2'b0, p.now_seconds};
      return mk(1, 1, STAT_CTRL_NEW);
    end
    for (int w = 0; w < NWAY; w++) begin
      e = base + w;
      if (!dat_tab[e].meta.valid) continue;
      if (hit < 0 && ((dat_tab[e].key.hosts == hf && dat_tab[e].key.ports == pf) ||
                      (dat_tab[e].key.hosts == hr && dat_tab[e].key.ports == pr)))
        hit = w;
      else if (is_stale(dat_tab[e].meta.ts, p.now_seconds))
        dat_tab[e].meta = '0;
    end
    if (hit >= 0) begin
      e = base + hit;
      if (p.flag_fin && p.flag_ack) begin
        dat_tab[e].meta = '0;
        return mk(1, 1, STAT_DATA_CLOS);
      end
      dat_tab[e].meta = {1'b1, p.now_seconds};
      return mk(1, 1, STAT_DATA_SEEN);
    end
    if ((p.src_port >= dlo && p.src_port <= dhi) || (p.dst_port >= dlo && p.dst_port <= dhi))
    begin
      for (int w = 0; w < NWAY; w++)
        if (ctl_tab[base + w].meta.valid && (ctl_tab[base + w].key.hosts == hf ||
                                             ctl_tab[base + w].key.hosts == hr))
          joined = 1'b1;
      if (!joined) return mk(0, 0, STAT_IGNORED);
      for (int w = 0; w < NWAY; w++)
        if (fw < 0 && !dat_tab[base + w].meta.valid) fw = w;
      if (fw < 0) return mk(1, 1, STAT_NO_ROOM);
      dat_tab[base + fw].key = {hf, pf};
      dat_tab[base + fw].meta = {1'b1, p.now_seconds};
      return mk(1, 1, STAT_DATA_NEW);
    end
    return mk(0, 0, STAT_IGNORED);
  endfunction

  function automatic bit gap_now();
    return !quiet_mode && ($urandom_range(99) < 28);
  endfunction

  // result checker and ready driver
  always @(negedge clk_i) res_if.ready <= rst_ni && !gap_now();

  always @(posedge clk_i) begin
    res_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_if.data);
      end else begin
        exp_r = expected_q.pop_front();
        if (res_if.data.accept !== exp_r.accept || res_if.data.mark_color !== exp_r.mark_color
            || res_if.data.status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0b %0b %s, got %0b %0b %0d",
                     exp_r.accept, exp_r.mark_color, exp_r.status.name(),
                     res_if.data.accept, res_if.data.mark_color, res_if.data.status);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_packet(pkt_t p);
    while (gap_now()) @(negedge clk_i);
    pkt_if.data <= p;
    pkt_if.valid <= 1'b1;
    do @(posedge clk_i); while (!pkt_if.ready);
    expected_q.push_back(classify_packet(p));
    @(negedge clk_i);
    pkt_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    cfg_if.data <= {idx, v};
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_CONTROL_PORT:   ctl_port = v[15:0];
      REG_DATA_PORT_LOW:  dlo = v[15:0];
      REG_DATA_PORT_HIGH: dhi = v[15:0];
      REG_IDLE_TIMEOUT:   idle_tmo = v;
      REG_FTP_COLOR:      own_color = v[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic pkt_t flow_pkt(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                    logic [15:0] dp, logic s, logic f, logic a);
    pkt_t p;
    p.packet_color = 8'd0;
    p.is_tcp_ipv4 = 1'b1;
    p.src_addr = sa;
    p.dst_addr = da;
    p.src_port = sp;
    p.dst_port = dp;
    p.flag_syn = s;
    p.flag_fin = f;
    p.flag_ack = a;
    p.now_seconds = clock_s;
    return p;
  endfunction

  task automatic test_directed();
    pkt_t p;
    p = flow_pkt(32'h0a000001, 32'h0a000002, 16'd40000, ctl_port, 0, 0, 1);
    send_packet(p);                       // untracked control
    p.flag_syn = 1; send_packet(p);       // ctrl new
    p = flow_pkt(32'h0a000002, 32'h0a000001, ctl_port, 16'd40000, 0, 0, 1);
    send_packet(p);                       // reverse direction seen
    p = flow_pkt(32'h0a000001, 32'h0a000002, 16'd20000, 16'd50000, 0, 0, 1);
    send_packet(p);                       // data new
    send_packet(p);                       // data seen
    p.flag_fin = 1; send_packet(p);       // data closed
    p = flow_pkt(32'h0a000002, 32'h0a000001, 16'd51000, 16'd25000, 0, 0, 0);
    send_packet(p);
    p = flow_pkt(32'h0a000001, 32'h0a000002, 16'd40000, ctl_port, 0, 1, 0);
    send_packet(p);
    p.flag_ack = 1; send_packet(p);
    p.flag_fin = 0; send_packet(p);       // ctrl closed, data purged
    p = flow_pkt(32'h0a000002, 32'h0a000001, 16'd51000, 16'd25000, 0, 0, 0);
    send_packet(p);
    for (int i = 0; i < 5; i++) begin     // full bucket
      p = flow_pkt(32'h00000010, 32'h00000000, 16'd1000 + i, ctl_port, 1, 0, 0);
      send_packet(p);
    end
    p = flow_pkt(32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 1, 1, 1);
    p.packet_color = 8'hff; send_packet(p);  // foreign color
    p.packet_color = 8'h00; p.is_tcp_ipv4 = 0; send_packet(p);
    p.is_tcp_ipv4 = 1; p.now_seconds = 32'hffffffff; send_packet(p);
    p = flow_pkt(0, 0, 0, 0, 0, 0, 0); p.packet_color = own_color; send_packet(p);
    drain();
  endtask

  function automatic pkt_t random_pkt();
    pkt_t p;
    logic [31:0] sa, da;
    int k;
    clock_s += $urandom_range(3);
    k = $urandom_range(5);
    sa = 32'h0a000000 | $urandom_range(7);
    da = 32'h0b000000 | ($urandom_range(3) << 8);
    if ($urandom_range(1)) begin
      sa = 32'h0b000000 | ($urandom_range(3) << 8);
      da = 32'h0a000000 | $urandom_range(7);
    end
    p = flow_pkt(sa, da, 16'd40000 + $urandom_range(2), ctl_port,
                 $urandom_range(1), $urandom_range(99) < 30, $urandom_range(1));
    if ($urandom_range(1)) begin p.src_port = ctl_port; p.dst_port = 16'd40000 + $urandom_range(2); end
    if (k >= 3) begin
      p.src_port = (dhi >= dlo) ? dlo + $urandom_range(dhi - dlo > 3 ? 3 : dhi - dlo)
                                : $urandom();
      p.dst_port = 16'd50000 + $urandom_range(2);
      p.flag_ack = $urandom_range(99) < 20 ? 1 : p.flag_ack;
    end
    if (k == 5) begin
      p = pkt_t'({$urandom(), $urandom(), $urandom(), $urandom()});
      p.now_seconds = clock_s + $urandom_range(200);
      if ($urandom_range(1)) p.packet_color = $urandom_range(1) ? 8'd0 : own_color;
      if ($urandom_range(1)) p.is_tcp_ipv4 = 1'b1;
    end
    return p;
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      send_packet(random_pkt());
      if (i == n / 2) drain();            // sender holds until all results are back
    end
    drain();
  endtask

  task automatic test_quiet(int n);
    quiet_mode = 1'b1;
    test_random(n);
    quiet_mode = 1'b0;
  endtask

  task automatic test_settings();
    write_reg(REG_IDLE_TIMEOUT, 32'd0);
    write_reg(REG_FTP_COLOR, 32'd255);
    test_random(120);
    write_reg(REG_CONTROL_PORT, 32'd65535);
    write_reg(REG_DATA_PORT_LOW, 32'd0);
    write_reg(REG_DATA_PORT_HIGH, 32'd65535);
    write_reg(REG_IDLE_TIMEOUT, 32'hffffffff);
    write_reg(REG_FTP_COLOR, 32'd0);
    test_random(120);
    write_reg(REG_CONTROL_PORT, 32'd0);
    write_reg(REG_DATA_PORT_LOW, 32'd30000);
    write_reg(REG_DATA_PORT_HIGH, 32'd29999);
    write_reg(REG_IDLE_TIMEOUT, 32'd5);
    write_reg(REG_FTP_COLOR, 32'd1);
    test_random(80);
  endtask

  initial begin
    ctl_port = RstControlPort;
    dlo = RstDataPortLow;
    dhi = RstDataPortHigh;
    idle_tmo = RstIdleTimeout;
    own_color = RstFtpColor;
    for (int i = 0; i < NENT; i++) begin
      ctl_tab[i] = '0;
      dat_tab[i] = '0;
    end
    pkt_if.valid = 1'b0;
    pkt_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(200);
    test_quiet(80);
    test_settings();
    if (mismatches == 0 && expected_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/ftt_pkg.sv
hw/rtl/ftt_if.sv
hw/rtl/ftt_bucket_hash.sv
hw/rtl/ftp_flow_tracking_table_core.sv
test/ftp_flow_tracking_table_core_tb.sv
